@@ hw/rtl/slasm_pkg.sv @@
// ----------------------------------------------------------------------------
// slasm_pkg
// Shared types and constants of the serial line assembler: character codes,
// result kinds and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package slasm_pkg;

  // default line buffer size (one byte is kept spare, and lines hold at most size-2)
  localparam int LINE_BYTES_DEF = 64;

  // width of the line length field of a result
  localparam int LEN_W = 6;

  // command queue depth, a power of two
  localparam int QUEUE_DEPTH = 2;

  // special characters
  localparam logic [7:0] CH_ABORT = 8'd24;
  localparam logic [7:0] CH_QUERY = 8'd63;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // result kinds
  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_EMPTY = 3'd1,
    KIND_ABORT = 3'd2,
    KIND_QUERY = 3'd3,
    KIND_LONG  = 3'd4
  } kind_t;

  // back end operations
  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_LINE  = 2'd1,
    OP_EVENT = 2'd2
  } op_t;

  // command word: store a byte at an index, emit a line of count bytes,
  // or emit a single event of the given kind
  typedef struct packed {
    op_t              op;
    kind_t            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] count;
  } cmd_t;

endpackage

@@ hw/rtl/slasm_front.sv @@
// ----------------------------------------------------------------------------
// slasm_front
// Accepts received bytes, tracks the line fill and discard mode, and turns
// each byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module slasm_front #(
  parameter int LINE_BYTES = slasm_pkg::LINE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             halted,
  input  logic             q_full,
  output logic             q_push,
  output slasm_pkg::cmd_t  q_cmd
);
  import slasm_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);

  logic [AW-1:0] char_count;
  logic [AW-1:0] char_count_next;
  logic          discarding;
  logic          discarding_next;
  logic          emit;
  logic          accept;
  logic          full;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign full     = (char_count == AW'(LINE_BYTES - 1));
  assign q_push   = accept && emit;

  // byte classification, first match wins
  always_comb begin
    emit            = 1'b0;
    q_cmd.op        = OP_EVENT;
    q_cmd.kind      = KIND_BYTE;
    q_cmd.data      = 8'd0;
    q_cmd.count     = '0;
    char_count_next = char_count;
    discarding_next = discarding;
    priority if (rx_byte == CH_ABORT) begin
      char_count_next = '0;
      discarding_next = 1'b0;
      if (!halted) begin
        emit       = 1'b1;
        q_cmd.kind = KIND_ABORT;
      end
    end else if (rx_byte == CH_QUERY) begin
      emit       = 1'b1;
      q_cmd.kind = KIND_QUERY;
    end else if (discarding) begin
      if (rx_byte == CH_NL) begin
        discarding_next = 1'b0;
      end
    end else if (full) begin
      char_count_next = '0;
      discarding_next = 1'b1;
      emit            = 1'b1;
      q_cmd.kind      = KIND_LONG;
    end else if (rx_byte == CH_NL) begin
      char_count_next = '0;
      emit            = 1'b1;
      if (char_count == '0) begin
        q_cmd.kind = KIND_EMPTY;
      end else begin
        q_cmd.op    = OP_LINE;
        q_cmd.count = LEN_W'(char_count);
      end
    end else if (rx_byte == CH_CR) begin
      emit = 1'b0;
    end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
      if (char_count != '0) begin
        char_count_next = char_count - AW'(1);
      end
    end else begin
      emit            = 1'b1;
      q_cmd.op        = OP_STORE;
      q_cmd.data      = rx_byte;
      q_cmd.count     = LEN_W'(char_count);
      char_count_next = char_count + AW'(1);
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      char_count <= char_count_next;
      discarding <= discarding_next;
    end
  end

endmodule

@@ hw/rtl/slasm_queue.sv @@
// ----------------------------------------------------------------------------
// slasm_queue
// Small command queue between front end and back end.
// ----------------------------------------------------------------------------
module slasm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  slasm_pkg::cmd_t  push_cmd,
  output logic             full,
  output logic             pop_valid,
  output slasm_pkg::cmd_t  pop_cmd,
  input  logic             pop
);
  import slasm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full      = (fill == CW'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_cmd   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ hw/rtl/slasm_back.sv @@
// ----------------------------------------------------------------------------
// slasm_back
// Executes commands: writes line bytes into the line store, plays a stored
// line out byte by byte, and presents single events, all through one
// output register.
// ----------------------------------------------------------------------------
module slasm_back #(
  parameter int LINE_BYTES = slasm_pkg::LINE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  slasm_pkg::cmd_t             q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  kind,
  output logic [7:0]                  data,
  output logic [slasm_pkg::LEN_W-1:0] line_length,
  output logic                        last
);
  import slasm_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t        state;
  logic [7:0]    mem [LINE_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] idx;
  logic [AW-1:0] n;
  logic          out_free;
  logic          last_byte;
  logic          load_event;
  logic          load_byte;

  assign out_free   = !out_valid || out_ready;
  assign last_byte  = (idx == n - AW'(1));
  assign q_pop      = (state == ST_IDLE) && q_valid &&
                      (q_cmd.op != OP_EVENT || out_free);
  assign load_event = q_pop && (q_cmd.op == OP_EVENT);
  assign load_byte  = (state == ST_SEND) && out_free;

  // line store, written by store commands and read during playback
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_STORE) begin
      mem[q_cmd.count[AW-1:0]] <= q_cmd.data;
    end
    if (state == ST_READ) begin
      rd_data <= mem[idx];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_cmd.op == OP_LINE) begin
            n     <= q_cmd.count[AW-1:0];
            idx   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_SEND;
        ST_SEND: begin
          if (out_free) begin
            if (last_byte) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_event || load_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    priority if (load_event) begin
      kind        <= q_cmd.kind;
      data        <= 8'd0;
      line_length <= '0;
      last        <= 1'b1;
    end else if (load_byte) begin
      kind        <= KIND_BYTE;
      data        <= rd_data;
      line_length <= LEN_W'(n);
      last        <= last_byte;
    end
  end

endmodule

@@ hw/rtl/serial_line_assembler.sv @@
// ----------------------------------------------------------------------------
// serial_line_assembler
// Assembles received serial bytes into command lines and real-time events.
// ----------------------------------------------------------------------------
// Each received byte is classified combinationally by the front end, which keeps
// the line fill count and discard mode; bytes that need work become commands
// in a two-entry queue. The back end owns the line store: it takes a stored
// byte or a single event straight from the queue, an event only when the
// output register is free; a completed line holds the back end while it takes
// the command and then, for each byte, the registered read of the line store
// followed by the load of the output register, which waits while the output
// stalls. Input is taken whenever the queue has room; while the queue is full
// every byte waits, even one that needs no command (CR, erase, discarded
// bytes). The line store needs no clearing after reset.
module serial_line_assembler #(
  parameter int LINE_BYTES = slasm_pkg::LINE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  input  logic                        halted,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  kind,
  output logic [7:0]                  data,
  output logic [slasm_pkg::LEN_W-1:0] line_length,
  output logic                        last
);
  import slasm_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_valid;
  cmd_t q_pop_cmd;
  logic q_pop;

  // byte classification
  slasm_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .halted   (halted),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // command queue
  slasm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_cmd   (q_pop_cmd),
    .pop       (q_pop)
  );

  // line store and result output
  slasm_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_pop_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data        (data),
    .line_length (line_length),
    .last        (last)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial line assembler. A table of directed
// bytes covers erase, abort, query, empty, full and discarded lines. Random
// lines and noise then run under several traffic patterns, including a long
// output hold-off. Every result is checked against a line-buffer predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slasm_pkg::*;

  localparam int LINE_BYTES     = LINE_BYTES_DEF;
  localparam int AW             = $clog2(LINE_BYTES);
  localparam int WORK_TARGET    = 140;
  localparam int PHASE_WORK     = WORK_TARGET / 5;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PLAN_ROWS      = 29;

  // one result transaction as seen on the output channel
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             last;
  } line_result_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SILENT,
    CHK_EVENT
  } row_check_t;

  typedef struct {
    logic [7:0] rx;
    logic       halt;
    int         reps;
    row_check_t chk;
    kind_t      evt;
  } plan_row_t;

  // traffic patterns
  typedef enum logic [2:0] {
    PH_QUIET,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_PRESSURE
  } traffic_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [7:0]           rx_byte   = '0;
  logic                 halted    = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [2:0]           kind;
  logic [7:0]           data;
  logic [LEN_W-1:0]     line_length;
  logic                 last;

  // predictor state
  logic [7:0]           line_buf [LINE_BYTES];
  logic [6:0]           fill_count;
  logic                 discarding;
  line_result_t         step_res [$];
  line_result_t         pending_q [$];

  traffic_t             phase          = PH_QUIET;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  bit                   hold_done      = 1'b0;
  int                   errors         = 0;
  int                   work_items     = 0;
  int                   quiet_cycles   = 0;

  serial_line_assembler DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .halted      (halted),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data        (data),
    .line_length (line_length),
    .last        (last)
  );

  // directed stimulus
  plan_row_t plan [0:PLAN_ROWS-1] = '{
    '{CH_NL,    1'b0, 1,  CHK_EVENT,  KIND_EMPTY},  // empty line right after reset
    '{CH_ABORT, 1'b0, 1,  CHK_EVENT,  KIND_ABORT},
    '{CH_ABORT, 1'b1, 1,  CHK_SILENT, KIND_BYTE},   // abort while halted is silent
    '{CH_QUERY, 1'b1, 1,  CHK_EVENT,  KIND_QUERY},
    '{8'h41,    1'b0, 1,  CHK_SILENT, KIND_BYTE},
    '{8'h00,    1'b1, 1,  CHK_SILENT, KIND_BYTE},
    '{8'hFF,    1'b0, 1,  CHK_SILENT, KIND_BYTE},
    '{CH_CR,    1'b1, 1,  CHK_SILENT, KIND_BYTE},
    '{CH_BS,    1'b0, 1,  CHK_SILENT, KIND_BYTE},
    '{8'h42,    1'b1, 1,  CHK_SILENT, KIND_BYTE},
    '{CH_DEL,   1'b0, 1,  CHK_SILENT, KIND_BYTE},
    '{8'h80,    1'b1, 1,  CHK_SILENT, KIND_BYTE},
    '{CH_NL,    1'b0, 1,  CHK_MODEL,  KIND_BYTE},
    '{CH_BS,    1'b1, 1,  CHK_SILENT, KIND_BYTE},   // erase on an empty line
    '{CH_DEL,   1'b0, 1,  CHK_SILENT, KIND_BYTE},
    '{CH_NL,    1'b1, 1,  CHK_EVENT,  KIND_EMPTY},
    '{8'h55,    1'b0, 63, CHK_SILENT, KIND_BYTE},   // fill the buffer
    '{8'h7E,    1'b1, 1,  CHK_EVENT,  KIND_LONG},
    '{8'h31,    1'b0, 1,  CHK_SILENT, KIND_BYTE},   // dropped
    '{CH_QUERY, 1'b0, 1,  CHK_EVENT,  KIND_QUERY},  // query still answered
    '{CH_NL,    1'b1, 1,  CHK_SILENT, KIND_BYTE},   // ends discard mode
    '{8'hAA,    1'b1, 63, CHK_SILENT, KIND_BYTE},
    '{CH_NL,    1'b0, 1,  CHK_EVENT,  KIND_LONG},   // newline on a full buffer
    '{CH_NL,    1'b0, 1,  CHK_SILENT, KIND_BYTE},
    '{8'h20,    1'b0, 62, CHK_SILENT, KIND_BYTE},   // longest line that survives
    '{CH_NL,    1'b1, 1,  CHK_MODEL,  KIND_BYTE},
    '{8'h61,    1'b0, 1,  CHK_SILENT, KIND_BYTE},
    '{CH_ABORT, 1'b0, 1,  CHK_EVENT,  KIND_ABORT},  // abort drops the line
    '{CH_NL,    1'b0, 1,  CHK_EVENT,  KIND_EMPTY}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic line_result_t mk_result(kind_t k, logic [7:0] d,
                                             logic [LEN_W-1:0] n, logic l);
    line_result_t r;
    r.kind = k;
    r.data = d;
    r.len  = n;
    r.last = l;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // line buffer predictor: results of one received byte go to step_res
  task automatic assemble_byte(input logic [7:0] b, input logic h, output bit ignored);
    int n;
    step_res.delete();
    ignored = 1'b0;
    if (b == CH_ABORT) begin
      fill_count = '0;
      discarding = 1'b0;
      if (!h) step_res = {step_res, mk_result(KIND_ABORT, 8'd0, '0, 1'b1)};
    end else if (b == CH_QUERY) begin
      step_res = {step_res, mk_result(KIND_QUERY, 8'd0, '0, 1'b1)};
    end else if (discarding) begin
      if (b == CH_NL) discarding = 1'b0;
      else ignored = 1'b1;
    end else if (fill_count >= LINE_BYTES - 1) begin
      fill_count = '0;
      discarding = 1'b1;
      step_res = {step_res, mk_result(KIND_LONG, 8'd0, '0, 1'b1)};
    end else if (b == CH_NL) begin
      n = int'(fill_count);
      fill_count = '0;
      if (n == 0) begin
        step_res = {step_res, mk_result(KIND_EMPTY, 8'd0, '0, 1'b1)};
      end else begin
        for (int i = 0; i < n; i++)
          step_res = {step_res,
                      mk_result(KIND_BYTE, line_buf[i], n[LEN_W-1:0], i == n - 1)};
      end
    end else if (b == CH_CR) begin
      ignored = 1'b1;
    end else if (b == CH_BS || b == CH_DEL) begin
      if (fill_count > 0) fill_count = fill_count - 7'(1);
    end else begin
      line_buf[fill_count[AW-1:0]] = b;
      fill_count = fill_count + 7'(1);
    end
  endtask

  task automatic set_traffic(traffic_t p);
    phase = p;
    send_idle_pct  = (p == PH_SEND_IDLE) ? 55 : (p == PH_BOTH) ? 10 : 0;
    recv_stall_pct = (p == PH_RECV_STALL) ? 55 : (p == PH_BOTH) ? 10 : 0;
  endtask

  // offer one byte, wait for the transaction, then record what it should cause
  task automatic send_byte(input logic [7:0] b, input logic h, input row_check_t chk,
                           input kind_t evt);
    bit ignored;
    rx_byte  <= b;
    halted   <= h;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    assemble_byte(b, h, ignored);
    if (!ignored) work_items++;
    case (chk)
      CHK_MODEL: begin
        pending_q = {pending_q, step_res};
      end
      CHK_EVENT: begin
        pending_q = {pending_q, mk_result(evt, 8'd0, '0, 1'b1)};
      end
      default: begin
      end
    endcase
    // sender gap
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // random payload byte with no special meaning
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == CH_NL || c == CH_ABORT || c == CH_QUERY || c == CH_CR ||
        c == CH_BS || c == CH_DEL)
      c = c ^ 8'h80;
    return c;
  endfunction

  // mostly well-formed lines with random content, sometimes raw noise
  task automatic send_random_line();
    int len;
    int r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 80) begin
      r = $urandom_range(99);
      if (r < 85) len = $urandom_range(8);
      else if (r < 95) len = $urandom_range(40, 9);
      else len = $urandom_range(68, 58);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 4) c = CH_BS;
        else if (r < 7) c = CH_DEL;
        else if (r < 9) c = CH_CR;
        else if (r < 11) c = CH_QUERY;
        else if (r < 12) c = CH_ABORT;
        else c = plain_byte();
        send_byte(c, 1'($urandom_range(1)), CHK_MODEL, KIND_BYTE);
      end
      send_byte(CH_NL, 1'($urandom_range(1)), CHK_MODEL, KIND_BYTE);
    end else begin
      repeat ($urandom_range(6, 1))
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), CHK_MODEL, KIND_BYTE);
    end
  endtask

  // output side: random stalls, one long hold-off in the pressure phase
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (phase == PH_PRESSURE && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    line_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, kind", int'(kind), 0);
      end else begin
        want = pending_q.pop_front();
        if (kind !== want.kind)
          report_mismatch("kind", int'(kind), int'(want.kind));
        if (data !== want.data)
          report_mismatch("data", int'(data), int'(want.data));
        if (line_length !== want.len)
          report_mismatch("line_length", int'(line_length), int'(want.len));
        if (last !== want.last)
          report_mismatch("last", int'(last), int'(want.last));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // main sequence
  initial begin
    fill_count = '0;
    discarding = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    set_traffic(PH_QUIET);
    foreach (plan[i]) begin
      repeat (plan[i].reps) send_byte(plan[i].rx, plan[i].halt, plan[i].chk, plan[i].evt);
    end

    // random lines under each traffic pattern
    work_items = 0;
    for (int p = 0; p < 5; p++) begin
      set_traffic(traffic_t'(p));
      while (work_items < (p + 1) * PHASE_WORK || (phase == PH_PRESSURE && !hold_done))
        send_random_line();
    end

    // drain
    set_traffic(PH_QUIET);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_q.size() != 0) report_mismatch("results missing", 0, pending_q.size());

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
